[hdl/bu_pkg.sv]
// Package for the branch unit stage queues: request/result structs,
// queue and cell control structs, sequencer states and register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bu_pkg;

  localparam int unsigned ISSUE_DEPTH   = 8;
  localparam int unsigned DECODE_DEPTH  = 8;
  localparam int unsigned READ_DEPTH    = 8;
  localparam int unsigned EXECUTE_DEPTH = 8;
  localparam int unsigned WRITE_DEPTH   = 8;
  localparam int unsigned TAG_BITS      = 16;
  localparam int unsigned WAIT_BITS     = 8;

  // queue numbers
  localparam logic [2:0] Q_ISSUE  = 3'd0;
  localparam logic [2:0] Q_DECODE = 3'd1;
  localparam logic [2:0] Q_READ   = 3'd2;
  localparam logic [2:0] Q_EXEC   = 3'd3;
  localparam logic [2:0] Q_WRITE  = 3'd4;

  // register indexes
  localparam logic [2:0] REG_STAGE_WIDTH = 3'd0;
  localparam logic [2:0] REG_DECODE_DLY  = 3'd1;
  localparam logic [2:0] REG_READ_DLY    = 3'd2;
  localparam logic [2:0] REG_EXEC_DLY    = 3'd3;
  localparam logic [2:0] REG_WB_DLY      = 3'd4;

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_ISSUE = 1'b1;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_ACK  = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [15:0] uop_tag;
    logic [7:0]  issue_delay;
  } req_t;

  typedef struct packed {
    logic        result_kind;
    logic        completed_valid;
    logic [15:0] completed_tag;
    logic        issue_accepted;
    logic        last_result;
  } result_t;

  typedef struct packed {
    logic pop;
    logic push;
    logic dec;
  } q_ctl_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic dec;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEC,
    ST_LOAD,
    ST_WALK,
    ST_FINISH
  } state_t;

endpackage
`default_nettype wire

[hdl/bu_cell.sv]
// One queue slot: tag plus remaining wait. Takes its right neighbour's
// entry on a shift, a new entry on a load, or counts its wait down.
// Depends on bu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bu_cell #(
  parameter int unsigned TAG_BITS = bu_pkg::TAG_BITS
) (
  input  wire                           clk,
  input  wire bu_pkg::cell_ctl_t        ctl,
  input  wire [TAG_BITS-1:0]            nxt_tag,
  input  wire [bu_pkg::WAIT_BITS-1:0]   nxt_left,
  input  wire [TAG_BITS-1:0]            new_tag,
  input  wire [bu_pkg::WAIT_BITS-1:0]   new_left,
  output logic [TAG_BITS-1:0]           tag,
  output logic [bu_pkg::WAIT_BITS-1:0]  left
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      tag  <= new_tag;
      left <= new_left;
    end else if (ctl.shift) begin
      tag  <= nxt_tag;
      left <= nxt_left;
    end else if (ctl.dec && left != '0) begin
      left <= left - 1'b1;
    end
  end

endmodule
`default_nettype wire

[hdl/bu_queue.sv]
// Ordered stage queue built as a row of bu_cell slots with a fill count.
// Pop shifts the row towards the head; push writes at the tail.
// Depends on bu_pkg and bu_cell.
`timescale 1ns / 1ps
`default_nettype none
module bu_queue #(
  parameter int unsigned DEPTH    = bu_pkg::ISSUE_DEPTH,
  parameter int unsigned TAG_BITS = bu_pkg::TAG_BITS,
  parameter int unsigned CW       = $clog2(DEPTH + 1)
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire bu_pkg::q_ctl_t           ctl,
  input  wire [TAG_BITS-1:0]            push_tag,
  input  wire [bu_pkg::WAIT_BITS-1:0]   push_left,
  output logic [TAG_BITS-1:0]           head_tag,
  output logic [bu_pkg::WAIT_BITS-1:0]  head_left,
  output logic [CW-1:0]                 count
);

  logic [TAG_BITS-1:0]          tags  [DEPTH];
  logic [bu_pkg::WAIT_BITS-1:0] lefts [DEPTH];
  logic [CW-1:0]                push_pos;

  // popping frees the head, so a recycled entry lands one place earlier
  assign push_pos = ctl.pop ? count - 1'b1 : count;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      bu_pkg::cell_ctl_t cc;
      logic [TAG_BITS-1:0]          nt;
      logic [bu_pkg::WAIT_BITS-1:0] nl;
      assign cc.shift = ctl.pop;
      assign cc.load  = ctl.push && (push_pos == CW'(i));
      assign cc.dec   = ctl.dec;
      if (i == DEPTH - 1) begin : g_last
        assign nt = tags[i];
        assign nl = lefts[i];
      end else begin : g_mid
        assign nt = tags[i+1];
        assign nl = lefts[i+1];
      end
      bu_cell #(.TAG_BITS(TAG_BITS)) u_cell (
        .clk      (clk),
        .ctl      (cc),
        .nxt_tag  (nt),
        .nxt_left (nl),
        .new_tag  (push_tag),
        .new_left (push_left),
        .tag      (tags[i]),
        .left     (lefts[i])
      );
    end
  endgenerate

  assign head_tag  = tags[0];
  assign head_left = lefts[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + CW'(ctl.push) - CW'(ctl.pop);
    end
  end

endmodule
`default_nettype wire

[hdl/branch_unit_stage_queues.sv]
// Branch unit stage queues: issue, decode, read, execute and write queues,
// each a row of cells, driven by one tick sequencer.
// Depends on bu_pkg, bu_queue.
//
// Usage: present a request on req with start high; it is taken at an edge
// where busy is low. An issue request appends to the issue queue unless it
// is full and gives one acknowledgement on result, with done high, in the
// next cycle; busy stays low, so requests may follow every cycle.
// A tick raises busy and runs: a state counting all waits down, then five
// walks: the write queue for completion, then the source queues of the
// write, execute, read and decode stages, in that order. Each walk is a load
// state, then steps through the entries of the walked queue, since its head
// cell is examined once a cycle while the row rotates, and a closing step.
// Then a finish state; the final result shows in the cycle after it. Retired
// tags are held back one step so the final one can carry last_result; each
// is shown for one cycle with done high, and the plain tick report comes
// with last_result set. Results cannot be held off by the receiver. Reset
// empties all queues and sets stage_width and the delays to 1. Config is an
// APB port; the user must make writes only while idle, which the block
// itself does not enforce.
`timescale 1ns / 1ps
`default_nettype none
module branch_unit_stage_queues #(
  parameter int unsigned ISSUE_DEPTH   = bu_pkg::ISSUE_DEPTH,
  parameter int unsigned DECODE_DEPTH  = bu_pkg::DECODE_DEPTH,
  parameter int unsigned READ_DEPTH    = bu_pkg::READ_DEPTH,
  parameter int unsigned EXECUTE_DEPTH = bu_pkg::EXECUTE_DEPTH,
  parameter int unsigned WRITE_DEPTH   = bu_pkg::WRITE_DEPTH,
  parameter int unsigned TAG_BITS      = bu_pkg::TAG_BITS
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    start,
  input  wire bu_pkg::req_t      req,
  output logic                   busy,
  output bu_pkg::result_t        result,
  output logic                   done,
  input  wire                    psel,
  input  wire                    penable,
  input  wire                    pwrite,
  input  wire [4:0]              paddr,
  input  wire [31:0]             pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int unsigned M1 = (ISSUE_DEPTH > DECODE_DEPTH) ? ISSUE_DEPTH : DECODE_DEPTH;
  localparam int unsigned M2 = (READ_DEPTH > EXECUTE_DEPTH) ? READ_DEPTH : EXECUTE_DEPTH;
  localparam int unsigned M3 = (M1 > M2) ? M1 : M2;
  localparam int unsigned MAXD = (M3 > WRITE_DEPTH) ? M3 : WRITE_DEPTH;
  localparam int unsigned CW = $clog2(MAXD + 1);
  localparam int unsigned CXW = (CW > 3) ? CW : 3;
  localparam int unsigned DEPTHS [5] = '{ISSUE_DEPTH, DECODE_DEPTH, READ_DEPTH,
                                         EXECUTE_DEPTH, WRITE_DEPTH};

  // configuration
  logic [2:0] stage_width;
  logic [7:0] decode_delay, read_delay, execute_delay, writeback_delay;
  logic [2:0] reg_idx;
  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_width     <= 3'd1;
      decode_delay    <= 8'd1;
      read_delay      <= 8'd1;
      execute_delay   <= 8'd1;
      writeback_delay <= 8'd1;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        bu_pkg::REG_STAGE_WIDTH: stage_width     <= pwdata[2:0];
        bu_pkg::REG_DECODE_DLY:  decode_delay    <= pwdata[7:0];
        bu_pkg::REG_READ_DLY:    read_delay      <= pwdata[7:0];
        bu_pkg::REG_EXEC_DLY:    execute_delay   <= pwdata[7:0];
        bu_pkg::REG_WB_DLY:      writeback_delay <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bu_pkg::REG_STAGE_WIDTH: prdata = {29'd0, stage_width};
      bu_pkg::REG_DECODE_DLY:  prdata = {24'd0, decode_delay};
      bu_pkg::REG_READ_DLY:    prdata = {24'd0, read_delay};
      bu_pkg::REG_EXEC_DLY:    prdata = {24'd0, execute_delay};
      bu_pkg::REG_WB_DLY:      prdata = {24'd0, writeback_delay};
      default:                 prdata = 32'd0;
    endcase
  end

  // queues
  bu_pkg::q_ctl_t                qctl      [5];
  logic [TAG_BITS-1:0]           push_tag  [5];
  logic [bu_pkg::WAIT_BITS-1:0]  push_left [5];
  logic [TAG_BITS-1:0]           head_tag  [5];
  logic [bu_pkg::WAIT_BITS-1:0]  head_left [5];
  logic [CW-1:0]                 count     [5];
  logic [4:0]                    full;

  genvar q;
  generate
    for (q = 0; q < 5; q++) begin : g_q
      localparam int unsigned QCW = $clog2(DEPTHS[q] + 1);
      logic [QCW-1:0] qcount;
      bu_queue #(.DEPTH(DEPTHS[q]), .TAG_BITS(TAG_BITS), .CW(QCW)) u_queue (
        .clk       (clk),
        .rst       (rst),
        .ctl       (qctl[q]),
        .push_tag  (push_tag[q]),
        .push_left (push_left[q]),
        .head_tag  (head_tag[q]),
        .head_left (head_left[q]),
        .count     (qcount)
      );
      assign count[q] = CW'(qcount);
      assign full[q]  = (count[q] == CW'(DEPTHS[q]));
    end
  endgenerate

  // sequencer
  bu_pkg::state_t state, state_next;
  logic [2:0]     src;
  logic [CW-1:0]  n, cnt;
  logic           pend_valid;
  logic [15:0]    pend_tag;
  logic [31:0]    in_tag32, head_tag32;
  logic [2:0]     dst;
  logic [7:0]     lat;
  logic           walk_step, ready, move;

  assign busy       = (state != bu_pkg::ST_IDLE);
  assign in_tag32   = {16'd0, req.uop_tag};
  assign head_tag32 = 32'(head_tag[bu_pkg::Q_WRITE]);
  assign dst        = src + 3'd1;
  assign walk_step  = (state == bu_pkg::ST_WALK) && (cnt != n);
  assign ready      = (head_left[src] == '0);
  // the examined count is cnt+1, so it may not pass stage_width
  assign move       = ready && (CXW'(cnt) < CXW'(stage_width)) && !full[dst];

  always_comb begin
    case (src)
      bu_pkg::Q_EXEC:   lat = writeback_delay;
      bu_pkg::Q_READ:   lat = execute_delay;
      bu_pkg::Q_DECODE: lat = read_delay;
      default:          lat = decode_delay;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      bu_pkg::ST_IDLE:
        if (start && req.req_type == bu_pkg::REQ_TICK) state_next = bu_pkg::ST_DEC;
      bu_pkg::ST_DEC:  state_next = bu_pkg::ST_LOAD;
      bu_pkg::ST_LOAD: state_next = bu_pkg::ST_WALK;
      bu_pkg::ST_WALK:
        if (cnt == n) state_next = (src == bu_pkg::Q_ISSUE) ? bu_pkg::ST_FINISH
                                                          : bu_pkg::ST_LOAD;
      bu_pkg::ST_FINISH: state_next = bu_pkg::ST_IDLE;
      default: state_next = bu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      qctl[k]      = '0;
      push_tag[k]  = head_tag[src];
      push_left[k] = head_left[src];
    end
    case (state)
      bu_pkg::ST_IDLE: begin
        if (start && req.req_type == bu_pkg::REQ_ISSUE) begin
          qctl[bu_pkg::Q_ISSUE].push = !full[bu_pkg::Q_ISSUE];
          push_tag[bu_pkg::Q_ISSUE]  = in_tag32[TAG_BITS-1:0];
          push_left[bu_pkg::Q_ISSUE] = req.issue_delay;
        end
      end
      bu_pkg::ST_DEC: begin
        for (int k = 0; k < 5; k++) qctl[k].dec = 1'b1;
      end
      bu_pkg::ST_WALK: begin
        if (walk_step) begin
          qctl[src].pop = 1'b1;
          if (src == bu_pkg::Q_WRITE) begin
            qctl[src].push = !ready;
          end else if (move) begin
            qctl[dst].push = 1'b1;
            push_left[dst] = lat;
          end else begin
            qctl[src].push = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bu_pkg::ST_IDLE;
      done       <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      case (state)
        bu_pkg::ST_IDLE:
          if (start && req.req_type == bu_pkg::REQ_ISSUE) begin
            done                   <= 1'b1;
            result.result_kind     <= bu_pkg::KIND_ACK;
            result.completed_valid <= 1'b0;
            result.completed_tag   <= 16'd0;
            result.issue_accepted  <= !full[bu_pkg::Q_ISSUE];
            result.last_result     <= 1'b1;
          end
        bu_pkg::ST_WALK:
          // a retired tag waits one step so the final one can carry last
          if (walk_step && src == bu_pkg::Q_WRITE && ready) begin
            pend_valid <= 1'b1;
            pend_tag   <= head_tag32[15:0];
            if (pend_valid) begin
              done                   <= 1'b1;
              result.result_kind     <= bu_pkg::KIND_TICK;
              result.completed_valid <= 1'b1;
              result.completed_tag   <= pend_tag;
              result.issue_accepted  <= 1'b0;
              result.last_result     <= 1'b0;
            end
          end
        bu_pkg::ST_FINISH: begin
          pend_valid             <= 1'b0;
          done                   <= 1'b1;
          result.result_kind     <= bu_pkg::KIND_TICK;
          result.completed_valid <= pend_valid;
          result.completed_tag   <= pend_valid ? pend_tag : 16'd0;
          result.issue_accepted  <= 1'b0;
          result.last_result     <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      bu_pkg::ST_DEC: src <= bu_pkg::Q_WRITE;
      bu_pkg::ST_LOAD: begin
        n   <= count[src];
        cnt <= '0;
      end
      bu_pkg::ST_WALK:
        if (cnt == n) src <= src - 3'd1;
        else          cnt <= cnt + 1'b1;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[tb/sv/tb_branch_unit_stage_queues.sv]
// Testbench for branch_unit_stage_queues: directed and random issue/tick requests
// against an in-bench model of the five stage queues, with APB setup between phases.
// Depends on bu_pkg and the branch_unit_stage_queues RTL.
`timescale 1ns / 1ps
module tb_branch_unit_stage_queues;

  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  bu_pkg::req_t req = '0;
  logic busy;
  bu_pkg::result_t result;
  logic done;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  branch_unit_stage_queues u_top (
    .clk(clk), .rst(rst), .start(start), .req(req), .busy(busy),
    .result(result), .done(done), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  typedef struct {
    logic [15:0] tag;
    logic [7:0]  left;
  } entry_t;

  // model state
  entry_t      stage_q[5][8];
  int unsigned stage_occ[5];
  int unsigned q_depth[5] = '{bu_pkg::ISSUE_DEPTH, bu_pkg::DECODE_DEPTH, bu_pkg::READ_DEPTH,
                              bu_pkg::EXECUTE_DEPTH, bu_pkg::WRITE_DEPTH};
  logic [2:0]  width_cfg;
  logic [7:0]  dly_cfg[5];   // indexed by register number, 0 unused

  bu_pkg::result_t pending_results[$];
  int      n_mismatch = 0;
  int      n_checked = 0;
  int      n_retired = 0;
  int      n_requests = 0;
  int      cycle_count = 0;
  int      gap_pct = 0;

  function automatic void model_reset();
    for (int q = 0; q < 5; q++) stage_occ[q] = 0;
    width_cfg = 3'd1;
    for (int r = 0; r < 5; r++) dly_cfg[r] = 8'd1;
  endfunction

  function automatic void move_stage(int src, int dst, logic [7:0] lat);
    int unsigned kept, seen;
    entry_t e;
    kept = 0;
    seen = 0;
    for (int i = 0; i < stage_occ[src]; i++) begin
      e = stage_q[src][i];
      seen++;
      if (e.left == 0 && seen <= width_cfg && stage_occ[dst] < q_depth[dst]) begin
        e.left = lat;
        stage_q[dst][stage_occ[dst]] = e;
        stage_occ[dst]++;
      end else begin
        stage_q[src][kept] = e;
        kept++;
      end
    end
    stage_occ[src] = kept;
  endfunction

  // works out the results of one accepted request and queues them
  function automatic void predict_request(bu_pkg::req_t r);
    bu_pkg::result_t res;
    bu_pkg::result_t retired[$];
    int unsigned kept;
    if (r.req_type == bu_pkg::REQ_ISSUE) begin
      res = '0;
      res.result_kind = bu_pkg::KIND_ACK;
      res.last_result = 1'b1;
      if (stage_occ[bu_pkg::Q_ISSUE] < q_depth[bu_pkg::Q_ISSUE]) begin
        stage_q[bu_pkg::Q_ISSUE][stage_occ[bu_pkg::Q_ISSUE]].tag = r.uop_tag;
        stage_q[bu_pkg::Q_ISSUE][stage_occ[bu_pkg::Q_ISSUE]].left = r.issue_delay;
        stage_occ[bu_pkg::Q_ISSUE]++;
        res.issue_accepted = 1'b1;
      end
      pending_results.push_back(res);
      return;
    end
    for (int q = 0; q < 5; q++)
      for (int i = 0; i < stage_occ[q]; i++)
        if (stage_q[q][i].left > 0) stage_q[q][i].left--;
    kept = 0;
    for (int i = 0; i < stage_occ[bu_pkg::Q_WRITE]; i++) begin
      if (stage_q[bu_pkg::Q_WRITE][i].left == 0) begin
        res = '0;
        res.result_kind = bu_pkg::KIND_TICK;
        res.completed_valid = 1'b1;
        res.completed_tag = stage_q[bu_pkg::Q_WRITE][i].tag;
        retired.push_back(res);
      end else begin
        stage_q[bu_pkg::Q_WRITE][kept] = stage_q[bu_pkg::Q_WRITE][i];
        kept++;
      end
    end
    stage_occ[bu_pkg::Q_WRITE] = kept;
    move_stage(bu_pkg::Q_EXEC, bu_pkg::Q_WRITE, dly_cfg[bu_pkg::REG_WB_DLY]);
    move_stage(bu_pkg::Q_READ, bu_pkg::Q_EXEC, dly_cfg[bu_pkg::REG_EXEC_DLY]);
    move_stage(bu_pkg::Q_DECODE, bu_pkg::Q_READ, dly_cfg[bu_pkg::REG_READ_DLY]);
    move_stage(bu_pkg::Q_ISSUE, bu_pkg::Q_DECODE, dly_cfg[bu_pkg::REG_DECODE_DLY]);
    if (retired.size() == 0) begin
      res = '0;
      res.result_kind = bu_pkg::KIND_TICK;
      res.last_result = 1'b1;
      pending_results.push_back(res);
    end else begin
      n_retired += retired.size();
      for (int i = 0; i < retired.size(); i++) begin
        res = retired[i];
        res.last_result = (i == retired.size() - 1);
        pending_results.push_back(res);
      end
    end
  endfunction

  // result checker: done is a one-cycle strobe, no back-pressure
  always @(posedge clk) begin
    bu_pkg::result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("ERROR: unexpected result %h at cycle %0d", result, cycle_count);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (result !== want) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("ERROR: cycle %0d kind %b/%b valid %b/%b tag %h/%h acc %b/%b last %b/%b",
                     cycle_count, want.result_kind, result.result_kind,
                     want.completed_valid, result.completed_valid,
                     want.completed_tag, result.completed_tag,
                     want.issue_accepted, result.issue_accepted,
                     want.last_result, result.last_result);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // holds start high until the request is taken; then drops it or keeps it for the next
  task automatic send_request(bu_pkg::req_t r, bit keep_start);
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    predict_request(r);
    n_requests++;
    if (!keep_start) start <= 1'b0;
  endtask

  task automatic send_with_gap(bu_pkg::req_t r);
    bit gap;
    gap = ($urandom_range(0, 99) < gap_pct);
    send_request(r, !gap);
    if (gap) repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  task automatic send_issue(logic [15:0] tag, logic [7:0] dly);
    bu_pkg::req_t r;
    r.req_type = bu_pkg::REQ_ISSUE;
    r.uop_tag = tag;
    r.issue_delay = dly;
    send_with_gap(r);
  endtask

  task automatic send_tick();
    bu_pkg::req_t r;
    r.req_type = bu_pkg::REQ_TICK;
    r.uop_tag = 16'($urandom);
    r.issue_delay = 8'($urandom);
    send_with_gap(r);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == bu_pkg::REG_STAGE_WIDTH) width_cfg = val[2:0];
    else dly_cfg[idx] = val[7:0];
  endtask

  task automatic set_config(logic [2:0] w, logic [7:0] d_dec, logic [7:0] d_rd,
                            logic [7:0] d_ex, logic [7:0] d_wb);
    drain();
    write_reg(bu_pkg::REG_STAGE_WIDTH, {29'd0, w});
    write_reg(bu_pkg::REG_DECODE_DLY, {24'd0, d_dec});
    write_reg(bu_pkg::REG_READ_DLY, {24'd0, d_rd});
    write_reg(bu_pkg::REG_EXEC_DLY, {24'd0, d_ex});
    write_reg(bu_pkg::REG_WB_DLY, {24'd0, d_wb});
  endtask

  // fills the issue queue past full, with extreme tags and waits, then ticks
  task automatic test_directed();
    set_config(3'd4, 8'd1, 8'd1, 8'd1, 8'd1);
    send_issue(16'h0000, 8'd0);
    send_issue(16'hFFFF, 8'd1);
    send_issue(16'hAAAA, 8'd2);
    send_issue(16'h5555, 8'd0);
    send_issue(16'h0001, 8'd3);
    send_issue(16'h8000, 8'd1);
    send_issue(16'h7FFF, 8'd0);
    send_issue(16'h1234, 8'd255);
    send_issue(16'hBEEF, 8'd0);   // queue full, rejected
    repeat (12) send_tick();
  endtask

  // stage width zero freezes every move; seven lets up to seven of the eight entries move
  task automatic test_width_extremes();
    set_config(3'd0, 8'd1, 8'd1, 8'd1, 8'd1);
    send_issue(16'($urandom), 8'd0);
    repeat (3) send_tick();
    set_config(3'd7, 8'd0, 8'd0, 8'd0, 8'd0);
    repeat (10) send_tick();
  endtask

  task automatic test_random(int n, int pct);
    gap_pct = pct;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 40)
        send_issue(16'($urandom),
                   ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3)));
      else
        send_tick();
    end
  endtask

  task automatic test_long_delays();
    set_config(3'd2, 8'd255, 8'd255, 8'd255, 8'd255);
    gap_pct = 0;
    repeat (4) send_issue(16'($urandom), 8'd0);
    repeat (6) send_tick();
  endtask

  initial begin
    model_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_width_extremes();
    set_config(3'd1, 8'd1, 8'd1, 8'd1, 8'd1);
    test_random(12, 0);
    set_config(3'd3, 8'd2, 8'd1, 8'd3, 8'd1);
    test_random(12, 60);
    drain();   // sender holds off until all results are in
    test_random(4, 60);
    set_config(3'd4, 8'd1, 8'd2, 8'd1, 8'd2);
    test_random(12, 16);
    test_long_delays();
    set_config(3'd2, 8'd1, 8'd1, 8'd1, 8'd1);
    test_random(10, 0);
    repeat (8) send_tick();
    drain();

    if (pending_results.size() != 0) n_mismatch += pending_results.size();
    $display("Sent %0d requests over several width and delay settings, idle levels 0/60/16.",
             n_requests);
    $display("Checked %0d results, %0d of them retired tags.", n_checked, n_retired);
    if (n_mismatch == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Mismatches: %0d", n_mismatch);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/bu_pkg.sv
hdl/bu_cell.sv
hdl/bu_queue.sv
hdl/branch_unit_stage_queues.sv
tb/sv/tb_branch_unit_stage_queues.sv
